/* rtl/core/jads_pkg.sv */
// Shared types and constants for the joystick axis dead-zone scaler.
// No dependencies; imported by the scaler top level.
`default_nettype none

package jads_pkg;

    // Output and full-scale field widths
    localparam int POS_BITS  = 13;
    localparam int FULL_BITS = 12;

    // Divider shape: quotient bits, bits resolved per stage, stage count
    localparam int QUOT_BITS      = 12;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUOT_BITS / BITS_PER_STAGE;

    // Register reset values, masked to the sample width where used
    localparam logic [31:0] RST_RAW_MIN        = 32'd18;
    localparam logic [31:0] RST_RAW_MAX        = 32'd4081;
    localparam logic [31:0] RST_RAW_CENTER     = 32'd2010;
    localparam logic [31:0] RST_DEAD_ZONE_HALF = 32'd200;
    localparam logic [FULL_BITS-1:0] RST_NEGATIVE_FULL = 12'h800;
    localparam logic [FULL_BITS-1:0] RST_POSITIVE_FULL = 12'h800;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        IDX_RAW_MIN        = 3'd0,
        IDX_RAW_MAX        = 3'd1,
        IDX_RAW_CENTER     = 3'd2,
        IDX_DEAD_ZONE_HALF = 3'd3,
        IDX_NEGATIVE_FULL  = 3'd4,
        IDX_POSITIVE_FULL  = 3'd5
    } reg_idx_t;

    // How an item's position is formed at the end of the pipeline
    typedef enum logic [2:0] {
        K_ZERO,
        K_ERR,
        K_SAT_NEG,
        K_SAT_POS,
        K_DIV
    } item_kind_t;

endpackage

`default_nettype wire

/* rtl/core/joystick_axis_deadzone_scaler.sv */
// Joystick axis dead-zone scaler: maps one raw converter sample to a signed position.
// Depends on jads_pkg for widths, register indexes and the item kind type.
`default_nettype none

// One item enters per cycle (busy stays low) and its result appears on position and
// config_error with a one-cycle done strobe. The pipeline is one classify stage and
// one multiply stage, followed by the 12-bit restoring divider, which resolves two
// quotient bits in each of six stages. The receiver cannot stall the block, so
// results leave in input order on fixed timing. The user must write configuration
// over the APB port only while no item is in flight; the block does not enforce it.
module joystick_axis_deadzone_scaler #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [SAMPLE_BITS-1:0]         sample,
    // result channel
    output logic                                done,
    output logic signed [jads_pkg::POS_BITS-1:0] position,
    output logic                                config_error,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [4:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import jads_pkg::*;

    localparam int SB        = SAMPLE_BITS;
    localparam int PROD_BITS = SB + QUOT_BITS;

    // Configuration registers
    logic [SB-1:0]        raw_min_reg;
    logic [SB-1:0]        raw_max_reg;
    logic [SB-1:0]        raw_center_reg;
    logic [SB-1:0]        dead_zone_half_reg;
    logic [FULL_BITS-1:0] negative_full_reg;
    logic [FULL_BITS-1:0] positive_full_reg;

    logic cfg_write;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_min_reg        <= RST_RAW_MIN[SB-1:0];
            raw_max_reg        <= RST_RAW_MAX[SB-1:0];
            raw_center_reg     <= RST_RAW_CENTER[SB-1:0];
            dead_zone_half_reg <= RST_DEAD_ZONE_HALF[SB-1:0];
            negative_full_reg  <= RST_NEGATIVE_FULL;
            positive_full_reg  <= RST_POSITIVE_FULL;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                IDX_RAW_MIN:        raw_min_reg        <= pwdata[SB-1:0];
                IDX_RAW_MAX:        raw_max_reg        <= pwdata[SB-1:0];
                IDX_RAW_CENTER:     raw_center_reg     <= pwdata[SB-1:0];
                IDX_DEAD_ZONE_HALF: dead_zone_half_reg <= pwdata[SB-1:0];
                IDX_NEGATIVE_FULL:  negative_full_reg  <= pwdata[FULL_BITS-1:0];
                IDX_POSITIVE_FULL:  positive_full_reg  <= pwdata[FULL_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (paddr[4:2])
            IDX_RAW_MIN:        prdata = {{(32-SB){1'b0}}, raw_min_reg};
            IDX_RAW_MAX:        prdata = {{(32-SB){1'b0}}, raw_max_reg};
            IDX_RAW_CENTER:     prdata = {{(32-SB){1'b0}}, raw_center_reg};
            IDX_DEAD_ZONE_HALF: prdata = {{(32-SB){1'b0}}, dead_zone_half_reg};
            IDX_NEGATIVE_FULL:  prdata = {{(32-FULL_BITS){negative_full_reg[FULL_BITS-1]}},
                                          negative_full_reg};
            IDX_POSITIVE_FULL:  prdata = {{(32-FULL_BITS){1'b0}}, positive_full_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Classify stage: dead zone, side of center, divisor, saturation
    // ------------------------------------------------------------------
    logic                 in_accept;
    logic [SB:0]          s_ext, c_ext, lo_ext, hi_ext, dz_ext;
    logic                 in_dead;
    logic [POS_BITS-1:0]  nf_neg;
    item_kind_t           cls_kind;
    logic                 cls_neg;
    logic [SB-1:0]        cls_diff;
    logic [FULL_BITS-1:0] cls_mag;
    logic [SB-1:0]        cls_span;

    assign in_accept = start && !busy;
    assign s_ext     = {1'b0, sample};
    assign c_ext     = {1'b0, raw_center_reg};
    assign lo_ext    = {1'b0, raw_min_reg};
    assign hi_ext    = {1'b0, raw_max_reg};
    assign dz_ext    = {1'b0, dead_zone_half_reg};
    assign in_dead   = (s_ext + dz_ext > c_ext) && (s_ext < c_ext + dz_ext);
    assign nf_neg    = -{negative_full_reg[FULL_BITS-1], negative_full_reg};

    always_comb
    begin
        cls_kind = K_ZERO;
        cls_neg  = 1'b0;
        cls_diff = '0;
        cls_mag  = '0;
        cls_span = '0;
        if (in_dead)
        begin
            cls_kind = K_ZERO;
        end
        else if (s_ext < c_ext)
        begin
            cls_diff = raw_center_reg - sample;
            cls_span = raw_center_reg - raw_min_reg;
            cls_neg  = negative_full_reg[FULL_BITS-1];
            cls_mag  = negative_full_reg[FULL_BITS-1] ? nf_neg[FULL_BITS-1:0]
                                                      : negative_full_reg;
            if (c_ext == lo_ext)
                cls_kind = K_ERR;
            else if (s_ext <= lo_ext)
                cls_kind = K_SAT_NEG;
            else
                cls_kind = K_DIV;
        end
        else if (s_ext > c_ext)
        begin
            cls_diff = sample - raw_center_reg;
            cls_span = raw_max_reg - raw_center_reg;
            cls_mag  = positive_full_reg;
            if (hi_ext == c_ext)
                cls_kind = K_ERR;
            else if (s_ext >= hi_ext)
                cls_kind = K_SAT_POS;
            else
                cls_kind = K_DIV;
        end
    end

    logic                 s1_valid_reg;
    item_kind_t           s1_kind_reg;
    logic                 s1_neg_reg;
    logic [SB-1:0]        s1_diff_reg;
    logic [FULL_BITS-1:0] s1_mag_reg;
    logic [SB-1:0]        s1_span_reg;

    // ------------------------------------------------------------------
    // Multiply stage
    // ------------------------------------------------------------------
    logic                 s2_valid_reg;
    item_kind_t           s2_kind_reg;
    logic                 s2_neg_reg;
    logic [PROD_BITS-1:0] s2_prod_reg;
    logic [SB-1:0]        s2_span_reg;

    // ------------------------------------------------------------------
    // Divider stages, two quotient bits each
    // ------------------------------------------------------------------
    logic                 dv_valid_reg [DIV_STAGES];
    item_kind_t           dv_kind_reg  [DIV_STAGES];
    logic                 dv_neg_reg   [DIV_STAGES];
    logic [SB-1:0]        dv_rem_reg   [DIV_STAGES];
    logic [QUOT_BITS-1:0] dv_num_reg   [DIV_STAGES];
    logic [QUOT_BITS-1:0] dv_quot_reg  [DIV_STAGES];
    logic [SB-1:0]        dv_span_reg  [DIV_STAGES];

    logic [SB-1:0]        dv_rem_next  [DIV_STAGES];
    logic [QUOT_BITS-1:0] dv_num_next  [DIV_STAGES];
    logic [QUOT_BITS-1:0] dv_quot_next [DIV_STAGES];

    // Restoring division steps for every stage
    always_comb
    begin
        logic [SB:0]          trial;
        logic [SB-1:0]        rem;
        logic [QUOT_BITS-1:0] num;
        logic [QUOT_BITS-1:0] quot;
        logic [SB-1:0]        span;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (i == 0)
            begin
                rem  = s2_prod_reg[PROD_BITS-1:QUOT_BITS];
                num  = s2_prod_reg[QUOT_BITS-1:0];
                quot = '0;
                span = s2_span_reg;
            end
            else
            begin
                rem  = dv_rem_reg[i-1];
                num  = dv_num_reg[i-1];
                quot = dv_quot_reg[i-1];
                span = dv_span_reg[i-1];
            end
            for (int b = 0; b < BITS_PER_STAGE; b++)
            begin
                trial = {rem, num[QUOT_BITS-1]};
                num   = {num[QUOT_BITS-2:0], 1'b0};
                if (trial >= {1'b0, span})
                begin
                    trial = trial - {1'b0, span};
                    quot  = {quot[QUOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    quot  = {quot[QUOT_BITS-2:0], 1'b0};
                end
                rem = trial[SB-1:0];
            end
            dv_rem_next[i]  = rem;
            dv_num_next[i]  = num;
            dv_quot_next[i] = quot;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: pick and sign the position
    // ------------------------------------------------------------------
    logic                 done_reg;
    logic [POS_BITS-1:0]  position_reg;
    logic                 config_error_reg;
    logic [POS_BITS-1:0]  position_next;
    logic                 config_error_next;
    logic [QUOT_BITS-1:0] last_quot;

    assign last_quot = dv_quot_reg[DIV_STAGES-1];

    always_comb
    begin
        position_next     = '0;
        config_error_next = 1'b0;
        case (dv_kind_reg[DIV_STAGES-1])
            K_ZERO:    position_next = '0;
            K_ERR:     config_error_next = 1'b1;
            K_SAT_NEG: position_next = {negative_full_reg[FULL_BITS-1], negative_full_reg};
            K_SAT_POS: position_next = {1'b0, positive_full_reg};
            K_DIV:     position_next = dv_neg_reg[DIV_STAGES-1] ? -{1'b0, last_quot}
                                                               : {1'b0, last_quot};
            default:   position_next = '0;
        endcase
    end

    // Advance valid bits through every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
                dv_valid_reg[i] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= in_accept;
            s2_valid_reg    <= s1_valid_reg;
            dv_valid_reg[0] <= s2_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            done_reg <= dv_valid_reg[DIV_STAGES-1];
        end
    end

    // Advance payload through every stage
    always_ff @(posedge clk)
    begin
        s1_kind_reg <= cls_kind;
        s1_neg_reg  <= cls_neg;
        s1_diff_reg <= cls_diff;
        s1_mag_reg  <= cls_mag;
        s1_span_reg <= cls_span;

        s2_kind_reg <= s1_kind_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_prod_reg <= s1_diff_reg * s1_mag_reg;
        s2_span_reg <= s1_span_reg;

        for (int i = 0; i < DIV_STAGES; i++)
        begin
            dv_rem_reg[i]  <= dv_rem_next[i];
            dv_num_reg[i]  <= dv_num_next[i];
            dv_quot_reg[i] <= dv_quot_next[i];
            if (i == 0)
            begin
                dv_kind_reg[i] <= s2_kind_reg;
                dv_neg_reg[i]  <= s2_neg_reg;
                dv_span_reg[i] <= s2_span_reg;
            end
            else
            begin
                dv_kind_reg[i] <= dv_kind_reg[i-1];
                dv_neg_reg[i]  <= dv_neg_reg[i-1];
                dv_span_reg[i] <= dv_span_reg[i-1];
            end
        end

        position_reg     <= position_next;
        config_error_reg <= config_error_next;
    end

    assign done         = done_reg;
    assign position     = position_reg;
    assign config_error = config_error_reg;

endmodule

`default_nettype wire
